@@ rtl/core/assert_macros.svh @@
// assertion macros for the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deque assertion failed");
// condition that must never be true outside reset
`define DEQ_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("deque forbidden condition seen");
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop)
`define DEQ_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/core/deq_pkg.sv @@
// deque package: operation and error codes, cell control struct
`default_nettype none
package deq_pkg;

    localparam int OP_W  = 3;
    localparam int ERR_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // per-lane command broadcast to every cell
    typedef struct packed {
        logic shr;  // insert at cell 0, everything moves one cell away
        logic shl;  // drop cell 0, everything moves one cell closer
        logic app;  // write the word into the cell at the count position
    } deq_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/deq_cell.sv @@
// deque cell: one stored word with neighbor handoff
`default_nettype none
module deq_cell #(
    parameter int DATA_WIDTH = 8,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  wire logic                  clk,
    input  wire deq_pkg::deq_ctl_t     ctl,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic [DATA_WIDTH-1:0] value,
    output logic      [DATA_WIDTH-1:0] data
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shr)
        begin
            data_next = left_data;
        end
        else if (ctl.shl)
        begin
            data_next = right_data;
        end
        else if (ctl.app && (count == CNT_W'(IDX)))
        begin
            data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

@@ rtl/core/deq_lane.sv @@
// deque lane: row of cells ordered from one end of the queue
`default_nettype none
module deq_lane #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8,
    parameter int CNT_W      = 5
) (
    input  wire logic                  clk,
    input  wire deq_pkg::deq_ctl_t     ctl,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [DATA_WIDTH-1:0] value,
    output logic      [DATA_WIDTH-1:0] head
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = value;
        end
        else
        begin : g_mid
            assign left_in = cell_data[i-1];
        end

        // last cell keeps its own word on a shift left; that word then lies past the count and is never read
        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_inner
            assign right_in = cell_data[i+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count),
            .left_data  (left_in),
            .right_data (right_in),
            .value      (value),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule
`default_nettype wire

@@ rtl/core/double_ended_queue_top.sv @@
// double-ended queue top level: op decode, entry count and result channel
//
// Bounded deque of DEPTH words. Each accepted op gives one result word that shows the
// front and back after the op, the entry count and an error code. The contents live in
// two rows of DEPTH cells, one ordered from the front and one from the back, so both
// ends always sit in a fixed cell and an op is at most one shift or write per row. One
// op word is taken per cycle unless stalled; the result is registered and appears the
// cycle after acceptance, and a new op is taken in the same cycle the pending result
// is taken. A full push or empty pop leaves the state unchanged and is flagged.
`default_nettype none
`include "assert_macros.svh"
module double_ended_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 8,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [deq_pkg::OP_W-1:0]   op,
    input  wire logic [DATA_WIDTH-1:0]      value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [DATA_WIDTH-1:0]      front_value,
    output logic                            front_valid,
    output logic      [DATA_WIDTH-1:0]      back_value,
    output logic                            back_valid,
    output logic      [CNT_W-1:0]           count,
    output logic      [deq_pkg::ERR_W-1:0]  error
);
    import deq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ERR_W-1:0] err_reg;
    logic [ERR_W-1:0] err_next;

    logic             in_acc;
    logic             is_full;
    logic             is_empty;
    logic [ERR_W-1:0] op_err;
    deq_ctl_t         front_ctl;
    deq_ctl_t         back_ctl;
    logic [DATA_WIDTH-1:0] front_head;
    logic [DATA_WIDTH-1:0] back_head;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        op_err     = ERR_OK;
        count_next = count_reg;
        front_ctl  = '0;
        back_ctl   = '0;
        case (op)
            OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    op_err = ERR_FULL;
                end
                else
                begin
                    front_ctl.app = in_acc;
                    back_ctl.shr  = in_acc;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    op_err = ERR_FULL;
                end
                else
                begin
                    front_ctl.shr = in_acc;
                    back_ctl.app  = in_acc;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    op_err = ERR_EMPTY;
                end
                else
                begin
                    front_ctl.shl = in_acc;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    op_err = ERR_EMPTY;
                end
                else
                begin
                    back_ctl.shl = in_acc;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                op_err = ERR_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        err_next       = err_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            err_next       = op_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
    end

    deq_lane #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_front_lane (
        .clk   (clk),
        .ctl   (front_ctl),
        .count (count_reg),
        .value (value),
        .head  (front_head)
    );

    deq_lane #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_back_lane (
        .clk   (clk),
        .ctl   (back_ctl),
        .count (count_reg),
        .value (value),
        .head  (back_head)
    );

    // state only moves on acceptance, so the view holds while the result stalls
    assign out_valid   = out_valid_reg;
    assign front_valid = !is_empty;
    assign back_valid  = !is_empty;
    assign front_value = is_empty ? '0 : front_head;
    assign back_value  = is_empty ? '0 : back_head;
    assign count       = count_reg;
    assign error       = err_reg;

    `DEQ_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(DEPTH))
    `DEQ_ASSERT(a_empty_err, clk, rst_n, (out_valid_reg && err_reg == ERR_EMPTY) |-> is_empty)
    `DEQ_ASSERT(a_full_err, clk, rst_n, (out_valid_reg && err_reg == ERR_FULL) |-> is_full)
    `DEQ_ASSERT(a_acc_result, clk, rst_n, in_acc |=> out_valid_reg)

endmodule
`default_nettype wire
